### src/cfpp_pkg.sv
// ----------------------------------------------------------------------------
// cfpp_pkg
// Shared types, constants and the byte-wise CRC-16 update of the parser.
// ----------------------------------------------------------------------------
package cfpp_pkg;

  localparam int unsigned MaxPayloadDefault = 64;
  localparam int unsigned FieldDepth        = 9;
  localparam int unsigned FieldIdxW         = $clog2(FieldDepth);

  localparam logic [7:0]  SyncByte     = 8'hAA;
  localparam logic [7:0]  PosByte      = 8'h55;
  localparam logic [7:0]  NoticeByte   = 8'hFF;
  localparam logic [7:0]  MissionFlag  = 8'h01;
  localparam logic [15:0] CrcInit      = 16'hFFFF;
  localparam logic [15:0] CrcTopBit    = 16'h8000;
  localparam logic [15:0] CrcPoly      = 16'h1021;

  typedef enum logic [2:0] {
    PhHead1   = 3'd0,
    PhHead2   = 3'd1,
    PhLength  = 3'd2,
    PhPayload = 3'd3,
    PhCrcLo   = 3'd4,
    PhCrcHi   = 3'd5,
    PhId      = 3'd6,
    PhFlag    = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    KindPosOk    = 2'd0,
    KindPosBad   = 2'd1,
    KindNotice   = 2'd2
  } frame_kind_e;

  typedef struct packed {
    frame_kind_e        kind;
    logic [7:0]         node_id;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic [7:0]         sender_id;
    logic               mission_end;
  } result_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcTopBit) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### src/cfpp_parser.sv
// ----------------------------------------------------------------------------
// cfpp_parser
// Frame state machine, payload field store and running CRC; one byte a step.
// ----------------------------------------------------------------------------
module cfpp_parser #(
  parameter int unsigned MAX_PAYLOAD = cfpp_pkg::MaxPayloadDefault,
  localparam int unsigned LenW = $clog2(MAX_PAYLOAD + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  output logic              res_valid_o,
  output cfpp_pkg::result_t res_o
);

  cfpp_pkg::phase_e phase_q, phase_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  idx_q, idx_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       crc_lo_q, crc_lo_d;
  logic [7:0]       sender_q, sender_d;
  logic [7:0]       field_q [cfpp_pkg::FieldDepth];
  logic             field_we;
  logic [LenW-1:0]  idx_inc;
  logic             len_bad;

  assign idx_inc  = idx_q + LenW'(1);
  assign len_bad  = (byte_i == 8'h00) || ({1'b0, byte_i} > 9'(MAX_PAYLOAD));
  assign field_we = step_i && (phase_q == cfpp_pkg::PhPayload) &&
                    (idx_q < LenW'(cfpp_pkg::FieldDepth));

  always_comb begin
    phase_d     = phase_q;
    len_d       = len_q;
    idx_d       = idx_q;
    crc_d       = crc_q;
    crc_lo_d    = crc_lo_q;
    sender_d    = sender_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (phase_q)
      cfpp_pkg::PhHead1: begin
        if (byte_i == cfpp_pkg::SyncByte) phase_d = cfpp_pkg::PhHead2;
      end
      cfpp_pkg::PhHead2: begin
        if (byte_i == cfpp_pkg::PosByte) begin
          phase_d = cfpp_pkg::PhLength;
        end else if (byte_i == cfpp_pkg::NoticeByte) begin
          phase_d = cfpp_pkg::PhId;
        end else begin
          phase_d = cfpp_pkg::PhHead1;
        end
      end
      cfpp_pkg::PhLength: begin
        len_d   = byte_i[LenW-1:0];
        idx_d   = '0;
        crc_d   = cfpp_pkg::CrcInit;
        phase_d = len_bad ? cfpp_pkg::PhHead1 : cfpp_pkg::PhPayload;
      end
      cfpp_pkg::PhPayload: begin
        crc_d = cfpp_pkg::crc_update(crc_q, byte_i);
        idx_d = idx_inc;
        if (idx_inc >= len_q) phase_d = cfpp_pkg::PhCrcLo;
      end
      cfpp_pkg::PhCrcLo: begin
        crc_lo_d = byte_i;
        phase_d  = cfpp_pkg::PhCrcHi;
      end
      cfpp_pkg::PhCrcHi: begin
        phase_d     = cfpp_pkg::PhHead1;
        res_valid_o = 1'b1;
        if ({byte_i, crc_lo_q} == crc_q) begin
          res_o.kind      = cfpp_pkg::KindPosOk;
          res_o.node_id   = field_q[0];
          res_o.latitude  = {field_q[4], field_q[3], field_q[2], field_q[1]};
          res_o.longitude = {field_q[8], field_q[7], field_q[6], field_q[5]};
        end else begin
          res_o.kind = cfpp_pkg::KindPosBad;
        end
      end
      cfpp_pkg::PhId: begin
        sender_d = byte_i;
        phase_d  = cfpp_pkg::PhFlag;
      end
      cfpp_pkg::PhFlag: begin
        phase_d           = cfpp_pkg::PhHead1;
        res_valid_o       = 1'b1;
        res_o.kind        = cfpp_pkg::KindNotice;
        res_o.sender_id   = sender_q;
        res_o.mission_end = (byte_i == cfpp_pkg::MissionFlag);
      end
      default: phase_d = cfpp_pkg::PhHead1;
    endcase
    if (!step_i) res_valid_o = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= cfpp_pkg::PhHead1;
      len_q    <= '0;
      idx_q    <= '0;
      crc_q    <= cfpp_pkg::CrcInit;
      crc_lo_q <= '0;
      sender_q <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      len_q    <= len_d;
      idx_q    <= idx_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
      sender_q <= sender_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cfpp_pkg::FieldDepth; i++) field_q[i] <= '0;
    end else if (field_we) begin
      field_q[idx_q[cfpp_pkg::FieldIdxW-1:0]] <= byte_i;
    end
  end

endmodule

### src/cfpp_out_reg.sv
// ----------------------------------------------------------------------------
// cfpp_out_reg
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module cfpp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  cfpp_pkg::result_t res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cfpp_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  cfpp_pkg::result_t res_q;

  assign free_o      = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

endmodule

### src/crc_framed_position_parser_core.sv
// ----------------------------------------------------------------------------
// crc_framed_position_parser_core
// Finds position and notice frames in a received byte stream.
// ----------------------------------------------------------------------------
// Input channel: one rx byte per item on rx_byte_i, taken when in_valid_i is
// high and in_stall_o is low. Output channel: one result item per complete
// frame (position accepted, CRC mismatch, or notice), offered on out_valid_o
// and taken when out_stall_i is low.
// Throughput: one byte per cycle while the result register is free; the
// per-byte CRC update is a single XOR network between the input register
// and the running CRC register. A frame's last byte is held in the input
// register, then its result is loaded into the result register once free.
// When the receiver stalls, the result register holds; one more byte is
// taken into the input register, then in_stall_o rises until the result
// leaves. Bytes that finish no frame also wait for a free result register.
// Reset clears the parser to hunt for the first sync byte, sets the CRC to
// its initial value and clears the stored payload fields; no result is
// pending afterwards.
// ----------------------------------------------------------------------------
module crc_framed_position_parser_core #(
  parameter int unsigned MAX_PAYLOAD = cfpp_pkg::MaxPayloadDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         frame_kind_o,
  output logic [7:0]         node_id_o,
  output logic signed [31:0] latitude_o,
  output logic signed [31:0] longitude_o,
  output logic [7:0]         sender_id_o,
  output logic               mission_end_o
);

  logic              in_valid_q, in_valid_d;
  logic [7:0]        byte_q;
  logic              accept;
  logic              step;
  logic              out_free;
  logic              res_valid;
  cfpp_pkg::result_t res;
  cfpp_pkg::result_t out_res;

  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) byte_q <= rx_byte_i;
  end

  cfpp_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (byte_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  cfpp_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_valid),
    .res_i      (res),
    .free_o     (out_free),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (out_res)
  );

  assign frame_kind_o  = out_res.kind;
  assign node_id_o     = out_res.node_id;
  assign latitude_o    = out_res.latitude;
  assign longitude_o   = out_res.longitude;
  assign sender_id_o   = out_res.sender_id;
  assign mission_end_o = out_res.mission_end;

  a_pos_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_kind_o != cfpp_pkg::KindPosOk) |->
      (node_id_o == 8'h00) && (latitude_o == 32'sd0) && (longitude_o == 32'sd0))
    else $error("position fields set on a non-accepted result");

  a_notice_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_kind_o != cfpp_pkg::KindNotice) |->
      (sender_id_o == 8'h00) && !mission_end_o)
    else $error("notice fields set on a position result");

  a_held_byte_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step |=> in_valid_q && $stable(byte_q))
    else $error("held input byte lost before it was parsed");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !out_valid_o || !out_stall_i)
    else $error("result written over a stalled result");

endmodule
